// ----- design/crc16_frame_parser_assert.svh -----
// ----------------------------------------------------------------------------
// crc16_frame_parser assertion macros
// Clocked assertion forms used by the frame parser control module.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_PARSER_ASSERT_SVH
`define CRC16_FRAME_PARSER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property that implies a condition in the next cycle.
`define FP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/crc16_fp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_fp_pkg
// Shared types and constants for the CRC-16 frame parser.
// ----------------------------------------------------------------------------
package crc16_fp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned FLAGS_SHIFT = 6;

  localparam logic [BYTE_W-1:0] SYNC_VALUE  = 8'hAA;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'h0000;
  localparam logic [LEN_W-1:0]  LIMIT_RESET = 11'd1019;
  localparam logic [LEN_W-1:0]  TRAILER_LEN = 11'd2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_FLAG_LO = 2'd1,
    PH_FLAG_HI = 2'd2,
    PH_BODY    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic              in_frame;
    logic              is_crc_byte;
    logic              frame_good;
    logic              frame_bad;
    logic              length_drop;
  } result_t;

endpackage

// ----- design/crc16_fp_crc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_fp_crc
// Bytewise CRC-16 update, polynomial 0x1021, MSB first, no reflection.
// ----------------------------------------------------------------------------
module crc16_fp_crc (
  input  logic [crc16_fp_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc16_fp_pkg::BYTE_W-1:0] data,
  output logic [crc16_fp_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [crc16_fp_pkg::CRC_W-1:0] c;
    c = crc_in ^ {data, {(crc16_fp_pkg::CRC_W - crc16_fp_pkg::BYTE_W){1'b0}}};
    for (int k = 0; k < crc16_fp_pkg::BYTE_W; k++) begin
      if (c[crc16_fp_pkg::CRC_W-1]) begin
        c = {c[crc16_fp_pkg::CRC_W-2:0], 1'b0} ^ crc16_fp_pkg::CRC_POLY;
      end else begin
        c = {c[crc16_fp_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- design/crc16_fp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_fp_ctrl
// Frame state machine: sync hunt, flag bytes, body count and CRC check.
// ----------------------------------------------------------------------------
`include "crc16_frame_parser_assert.svh"

module crc16_fp_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [crc16_fp_pkg::BYTE_W-1:0]  rx,
  input  logic [crc16_fp_pkg::LEN_W-1:0]   limit,
  output crc16_fp_pkg::result_t            res
);

  localparam int unsigned BW = crc16_fp_pkg::BYTE_W;
  localparam int unsigned CW = crc16_fp_pkg::CRC_W;
  localparam int unsigned LW = crc16_fp_pkg::LEN_W;

  crc16_fp_pkg::phase_t phase, phase_next;
  logic [LW-1:0] remaining, remaining_next;
  logic [CW-1:0] crc_running, crc_running_next;
  logic [BW-1:0] trailer_low, trailer_low_next;
  logic [LW-1:0] position, position_next;
  logic [BW-1:0] flags_low, flags_low_next;

  logic [CW-1:0] crc_base;
  logic [CW-1:0] crc_fed;
  logic [LW-1:0] total;
  logic          too_long;
  logic          crc_match;

  assign crc_base = (phase == crc16_fp_pkg::PH_HUNT) ? crc16_fp_pkg::CRC_INIT : crc_running;

  crc16_fp_crc u_crc (
    .crc_in  (crc_base),
    .data    (rx),
    .crc_out (crc_fed)
  );

  // Body length from the 16-bit flags word, plus the two trailer bytes.
  assign total     = LW'({rx, flags_low} >> crc16_fp_pkg::FLAGS_SHIFT)
                     + crc16_fp_pkg::TRAILER_LEN;
  assign too_long  = total > limit;
  assign crc_match = ({rx, trailer_low} == crc_running);

  // Next state
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    crc_running_next = crc_running;
    trailer_low_next = trailer_low;
    position_next    = position;
    flags_low_next   = flags_low;
    unique case (phase)
      crc16_fp_pkg::PH_HUNT: begin
        if (rx == crc16_fp_pkg::SYNC_VALUE) begin
          crc_running_next = crc_fed;
          position_next    = LW'(1);
          phase_next       = crc16_fp_pkg::PH_FLAG_LO;
        end
      end
      crc16_fp_pkg::PH_FLAG_LO: begin
        flags_low_next   = rx;
        crc_running_next = crc_fed;
        position_next    = LW'(2);
        phase_next       = crc16_fp_pkg::PH_FLAG_HI;
      end
      crc16_fp_pkg::PH_FLAG_HI: begin
        if (too_long) begin
          phase_next    = crc16_fp_pkg::PH_HUNT;
          position_next = '0;
        end else begin
          remaining_next   = total;
          crc_running_next = crc_fed;
          position_next    = LW'(3);
          phase_next       = crc16_fp_pkg::PH_BODY;
        end
      end
      crc16_fp_pkg::PH_BODY: begin
        position_next = position + LW'(1);
        if (remaining > crc16_fp_pkg::TRAILER_LEN) begin
          crc_running_next = crc_fed;
          remaining_next   = remaining - LW'(1);
        end else if (remaining == crc16_fp_pkg::TRAILER_LEN) begin
          trailer_low_next = rx;
          remaining_next   = LW'(1);
        end else begin
          remaining_next = '0;
          phase_next     = crc16_fp_pkg::PH_HUNT;
          position_next  = '0;
        end
      end
      default: phase_next = crc16_fp_pkg::PH_HUNT;
    endcase
  end

  // Outputs
  always_comb begin
    res             = '0;
    res.data_byte   = rx;
    unique case (phase)
      crc16_fp_pkg::PH_HUNT: begin
        res.in_frame = (rx == crc16_fp_pkg::SYNC_VALUE);
      end
      crc16_fp_pkg::PH_FLAG_LO: begin
        res.in_frame   = 1'b1;
        res.byte_index = position;
      end
      crc16_fp_pkg::PH_FLAG_HI: begin
        res.in_frame    = 1'b1;
        res.byte_index  = position;
        res.length_drop = too_long;
      end
      crc16_fp_pkg::PH_BODY: begin
        res.in_frame   = 1'b1;
        res.byte_index = position;
        if (remaining <= crc16_fp_pkg::TRAILER_LEN) begin
          res.is_crc_byte = 1'b1;
        end
        if (remaining < crc16_fp_pkg::TRAILER_LEN) begin
          res.frame_good = crc_match;
          res.frame_bad  = !crc_match;
        end
      end
      default: res.in_frame = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= crc16_fp_pkg::PH_HUNT;
      remaining   <= '0;
      crc_running <= crc16_fp_pkg::CRC_INIT;
      trailer_low <= '0;
      position    <= '0;
      flags_low   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      crc_running <= crc_running_next;
      trailer_low <= trailer_low_next;
      position    <= position_next;
      flags_low   <= flags_low_next;
    end
  end

  `FP_ASSERT(a_body_has_count, (phase != crc16_fp_pkg::PH_BODY) || (remaining != '0), "body with zero count")
  `FP_ASSERT_NEXT(a_end_to_hunt, step && (res.frame_good || res.frame_bad), (phase == crc16_fp_pkg::PH_HUNT) && (position == '0), "frame end did not return to hunt")
  `FP_ASSERT_NEXT(a_drop_to_hunt, step && res.length_drop, (phase == crc16_fp_pkg::PH_HUNT) && (position == '0), "length drop did not return to hunt")
  `FP_ASSERT_NEXT(a_flag_seq, step && (phase == crc16_fp_pkg::PH_FLAG_LO), phase == crc16_fp_pkg::PH_FLAG_HI, "flag bytes out of order")

endmodule

// ----- design/crc16_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_parser
// Length-prefixed serial frame parser with CRC-16/XMODEM trailer check.
// ----------------------------------------------------------------------------
// One result per received byte. A byte is captured in an input register, the
// frame state machine and a bytewise CRC-16 update act on it combinationally,
// and the result lands in an output register once the result side is free:
// the result passes the input register and then the output register, a step
// that a result-side stall can hold up, and the block takes a new byte every cycle as long as the result side is not
// stalled. The length limit register may be written at any time the port is
// ready (always) but should change only while no frame bytes are in flight.
module crc16_frame_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [crc16_fp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [crc16_fp_pkg::BYTE_W-1:0]  data_byte,
  output logic [crc16_fp_pkg::LEN_W-1:0]   byte_index,
  output logic                             in_frame,
  output logic                             is_crc_byte,
  output logic                             frame_good,
  output logic                             frame_bad,
  output logic                             length_drop,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crc16_fp_pkg::LEN_W-1:0]   cfg_data
);

  logic                            in_full;
  logic [crc16_fp_pkg::BYTE_W-1:0] in_byte;
  logic [crc16_fp_pkg::LEN_W-1:0]  length_limit;
  logic                            out_free;
  logic                            advance;
  logic                            accept;
  crc16_fp_pkg::result_t           res;
  crc16_fp_pkg::result_t           res_q;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && out_free;
  assign in_stall  = in_full && !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= crc16_fp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  // Input register: hold until the result register can take the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= rx_byte;
    end
  end

  crc16_fp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .rx    (in_byte),
    .limit (length_limit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign data_byte   = res_q.data_byte;
  assign byte_index  = res_q.byte_index;
  assign in_frame    = res_q.in_frame;
  assign is_crc_byte = res_q.is_crc_byte;
  assign frame_good  = res_q.frame_good;
  assign frame_bad   = res_q.frame_bad;
  assign length_drop = res_q.length_drop;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc16_frame_parser. It sends directed frames, then
// random runs of good, corrupted, oversize and truncated frames mixed with
// line noise, under several length limits. Both handshakes idle and stall at
// random. A scoreboard tracks the parser state, works out the echo for every
// accepted byte, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
  import crc16_fp_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int MAX_PRINTS = 30;

  // Tracks the parser state and holds the echo due for every accepted byte.
  class frame_tracker;
    phase_t              state;
    logic [LEN_W-1:0]    limit;
    logic [LEN_W-1:0]    left;
    logic [LEN_W-1:0]    pos;
    logic [CRC_W-1:0]    crc;
    logic [BYTE_W-1:0]   trail_lo;
    logic [BYTE_W-1:0]   flag_lo;
    result_t             pending_echoes[$];
    int                  errors;
    int                  checked;
    int                  n_good;
    int                  n_bad;
    int                  n_drop;

    function new();
      state = PH_HUNT;
      limit = LIMIT_RESET;
      left = '0;
      pos = '0;
      crc = CRC_INIT;
      trail_lo = '0;
      flag_lo = '0;
      errors = 0;
      checked = 0;
      n_good = 0;
      n_bad = 0;
      n_drop = 0;
    endfunction

    static function logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
      c = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (c[15]) c = (c << 1) ^ CRC_POLY;
        else c = c << 1;
      end
      return c;
    endfunction

    function int pending();
      return pending_echoes.size();
    endfunction

    function void note_request(logic [BYTE_W-1:0] b);
      result_t r;
      int total;
      r = '0;
      r.data_byte = b;
      case (state)
        PH_HUNT: begin
          if (b == SYNC_VALUE) begin
            r.in_frame = 1'b1;
            crc = crc_next(CRC_INIT, b);
            pos = 11'd1;
            state = PH_FLAG_LO;
          end
        end
        PH_FLAG_LO: begin
          r.in_frame = 1'b1;
          r.byte_index = pos;
          flag_lo = b;
          crc = crc_next(crc, b);
          pos = 11'd2;
          state = PH_FLAG_HI;
        end
        PH_FLAG_HI: begin
          total = int'({b, flag_lo} >> FLAGS_SHIFT) + int'(TRAILER_LEN);
          r.in_frame = 1'b1;
          r.byte_index = pos;
          if (total > int'(limit)) begin
            r.length_drop = 1'b1;
            n_drop++;
            state = PH_HUNT;
            pos = '0;
          end else begin
            left = total[LEN_W-1:0];
            crc = crc_next(crc, b);
            pos = 11'd3;
            state = PH_BODY;
          end
        end
        default: begin
          r.in_frame = 1'b1;
          r.byte_index = pos;
          pos = pos + 11'd1;
          if (left > TRAILER_LEN) begin
            crc = crc_next(crc, b);
            left = left - 11'd1;
          end else if (left == TRAILER_LEN) begin
            trail_lo = b;
            r.is_crc_byte = 1'b1;
            left = 11'd1;
          end else begin
            r.is_crc_byte = 1'b1;
            if ({b, trail_lo} == crc) begin
              r.frame_good = 1'b1;
              n_good++;
            end else begin
              r.frame_bad = 1'b1;
              n_bad++;
            end
            left = '0;
            state = PH_HUNT;
            pos = '0;
          end
        end
      endcase
      pending_echoes = {pending_echoes, r};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_echoes.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: unexpected result expected none actual byte %0d index %0d",
                   $time, got.data_byte, got.byte_index);
        return;
      end
      want = pending_echoes.pop_front();
      checked++;
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("in_frame", want.in_frame, got.in_frame);
      compare_field("is_crc_byte", want.is_crc_byte, got.is_crc_byte);
      compare_field("frame_good", want.frame_good, got.frame_good);
      compare_field("frame_bad", want.frame_bad, got.frame_bad);
      compare_field("length_drop", want.length_drop, got.length_drop);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  byte_index;
  logic              in_frame;
  logic              is_crc_byte;
  logic              frame_good;
  logic              frame_bad;
  logic              length_drop;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;

  frame_tracker      tracker = new();
  bit                no_idle = 1'b0;
  int                hold_req = 0;
  int                hold_left = 0;
  int                stall_left = 0;
  int                cycles = 0;
  int                limits_used[$];

  crc16_frame_parser u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .in_frame    (in_frame),
    .is_crc_byte (is_crc_byte),
    .frame_good  (frame_good),
    .frame_bad   (frame_bad),
    .length_drop (length_drop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
      $display("crc16_frame_parser: mismatch");
      $finish;
    end
  end

  // Note requests before checking, so an echo never races its own prediction.
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_request(rx_byte);
      if (out_valid && !out_stall) begin
        got.data_byte = data_byte;
        got.byte_index = byte_index;
        got.in_frame = in_frame;
        got.is_crc_byte = is_crc_byte;
        got.frame_good = frame_good;
        got.frame_bad = frame_bad;
        got.length_drop = length_drop;
        tracker.check_result(got);
      end
    end
  end

  // Result side: random stall after each accepted result, long hold on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (out_valid && !out_stall) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 12);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Leave valid high after acceptance so back-to-back requests need no toggle.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Build sync, flags, body and trailer; send all or the first keep bytes.
  // A frame over the limit stops after its header, the parser drops it there.
  task automatic send_frame(input logic [15:0] flags, input int fill, input bit spoil,
                            input int keep, output int sent);
    logic [BYTE_W-1:0] fb[$];
    logic [CRC_W-1:0]  c;
    int                dlen;
    int                n;
    int                k;
    fb = {};
    fb = {fb, SYNC_VALUE};
    fb = {fb, flags[7:0]};
    fb = {fb, flags[15:8]};
    dlen = int'(flags >> FLAGS_SHIFT);
    for (k = 0; k < dlen; k++) begin
      if (fill >= 0) fb = {fb, fill[7:0]};
      else if ($urandom_range(0, 15) == 0) fb = {fb, SYNC_VALUE};
      else fb = {fb, 8'($urandom)};
    end
    c = CRC_INIT;
    foreach (fb[i]) c = frame_tracker::crc_next(c, fb[i]);
    fb = {fb, c[7:0]};
    fb = {fb, c[15:8]};
    if (spoil) begin
      k = $urandom_range(3, fb.size() - 1);
      fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    n = fb.size();
    if (keep > 0 && keep < n) n = keep;
    if (dlen + 2 > int'(tracker.limit) && n > 3) n = 3;
    for (k = 0; k < n; k++) send_byte(fb[k]);
    sent = n;
  endtask

  // Hold the sender until every echo is back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.limit = v;
    limits_used = {limits_used, int'(v)};
  endtask

  function automatic logic [15:0] pick_flags(int maxd);
    int         d;
    logic [5:0] lo;
    d = ($urandom_range(0, 24) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
    if (d > maxd) d = maxd;
    if (d < 0) d = 0;
    lo = 6'($urandom);
    return {d[9:0], lo};
  endfunction

  task automatic run_random(input int quota);
    int          done;
    int          pick;
    int          sent;
    int          dmin;
    int          k;
    logic [15:0] flags;
    done = 0;
    while (done < quota) begin
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      flags = pick_flags(int'(tracker.limit) - 2);
      dmin = int'(tracker.limit) - 1;
      if (pick < 60) begin
        send_frame(flags, -1, 1'b0, 0, sent);
      end else if (pick < 72) begin
        send_frame(flags, -1, 1'b1, 0, sent);
      end else if (pick < 80 && dmin <= 1023) begin
        if (dmin < 0) dmin = 0;
        flags = {10'($urandom_range(dmin, 1023)), 6'($urandom)};
        send_frame(flags, -1, 1'b0, 3, sent);
      end else if (pick < 90) begin
        // cut short: the next sync lands inside the open frame as data
        send_frame(flags, -1, 1'b0, $urandom_range(1, int'(flags >> FLAGS_SHIFT) + 4), sent);
      end else begin
        sent = $urandom_range(1, 6);
        for (k = 0; k < sent; k++) send_byte(8'($urandom));
      end
      done += sent;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: noise, shortest frame, sync as data with bad CRC, oversize, fills
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'h003F, -1, 1'b0, 0, sent);
    send_frame(16'h0040, int'(SYNC_VALUE), 1'b1, 0, sent);
    send_frame(16'hFFFF, -1, 1'b0, 0, sent);
    send_frame(16'h0080, 8'hFF, 1'b0, 0, sent);
    drain();

    write_limit(11'd1025);
    // long frame with a long result-side hold: input must back up
    no_idle = 1'b1;
    hold_req = 300;
    send_frame(16'h3FC0, -1, 1'b0, 0, sent);
    no_idle = 1'b0;
    run_random(200);
    drain();

    write_limit(11'd0);
    run_random(40);
    drain();

    write_limit(11'd2);
    run_random(80);
    drain();

    write_limit(11'($urandom_range(3, 40)));
    run_random(130);
    drain();

    write_limit(11'($urandom_range(41, 1024)));
    run_random(150);
    drain();
    repeat (8) @(posedge clk);

    $display("checked %0d echoes: %0d frames good, %0d bad CRC, %0d dropped for length",
             tracker.checked, tracker.n_good, tracker.n_bad, tracker.n_drop);
    $display("length limits used: reset value then %p", limits_used);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("crc16_frame_parser: match");
    end else begin
      $display("crc16_frame_parser: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/crc16_fp_pkg.sv
design/crc16_fp_crc.sv
design/crc16_fp_ctrl.sv
design/crc16_frame_parser.sv
tb/sv/tb.sv
